// ----- rtl/bounded_denominator_fraction_search_unit_macros.svh -----
// Assertion macros shared by the block's checker.
`ifndef BOUNDED_DENOMINATOR_FRACTION_SEARCH_UNIT_MACROS_SVH
`define BOUNDED_DENOMINATOR_FRACTION_SEARCH_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle; uses clk and rst_n in scope.
`define BDFS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdfs: %s failed", "lbl");

// Antecedent implies consequent in the cycle after.
`define BDFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdfs: %s failed", "lbl");

// A stalled transfer keeps its payload.
`define BDFS_ASSERT_HOLD(lbl, vld, rdy, data) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    ((vld) && !(rdy)) |=> $stable(data)) \
    else $error("bdfs: %s failed", "lbl");

`endif

// ----- rtl/bdfs_pkg.sv -----
// Shared types and constants of the bounded-denominator fraction search.
package bdfs_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned DENOM_BITS_DEF    = 10;
  localparam int unsigned MAX_DENOM_RESET   = 16;

  typedef enum logic [0:0] {
    S_IDLE,
    S_STEP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic over;
    logic match;
  } dp_status_t;

endpackage

// ----- rtl/bdfs_datapath.sv -----
// Datapath: bounds, running products, limit register and result register.
module bdfs_datapath #(
  parameter int unsigned FRACTION_BITS = bdfs_pkg::FRACTION_BITS_DEF,
  parameter int unsigned DENOM_BITS    = bdfs_pkg::DENOM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [DENOM_BITS-1:0]    cfg_wr_data,
  input  logic [FRACTION_BITS:0]   tangent,
  input  bdfs_pkg::dp_cmd_t        cmd,
  output bdfs_pkg::dp_status_t     status,
  output logic [DENOM_BITS-1:0]    res_num,
  output logic [DENOM_BITS-1:0]    res_den
);

  localparam int unsigned BW = DENOM_BITS + 1;
  localparam int unsigned PW = FRACTION_BITS + 1 + BW;
  localparam int unsigned LIM_MAX = (2 ** DENOM_BITS) - 1;
  localparam int unsigned LIM_RST = (bdfs_pkg::MAX_DENOM_RESET > LIM_MAX) ?
                                    LIM_MAX : bdfs_pkg::MAX_DENOM_RESET;

  logic [DENOM_BITS-1:0] lim_r;
  logic [BW-1:0] lo_n_r, lo_d_r, up_n_r, up_d_r;
  logic [BW-1:0] lo_n_nxt, lo_d_nxt, up_n_nxt, up_d_nxt;
  logic [PW-1:0] plo_r, pup_r, plo_nxt, pup_nxt;
  logic [BW-1:0] res_n_r, res_d_r, res_n_nxt, res_d_nxt;
  logic [BW-1:0] lim_ext, m_n, m_d;
  logic [PW-1:0] lhs, rhs;
  logic          over, match, gt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= DENOM_BITS'(LIM_RST);
    end else if (cfg_wr_en) begin
      lim_r <= cfg_wr_data;
    end
  end

  // Products of the value with each bound's denominator are kept, so the
  // mediant's product is one add.
  always_comb begin
    lim_ext = {1'b0, lim_r};
    m_n     = lo_n_r + up_n_r;
    m_d     = lo_d_r + up_d_r;
    lhs     = plo_r + pup_r;
    rhs     = PW'({m_n, {FRACTION_BITS{1'b0}}});
    over    = (lo_d_r > lim_ext) || (up_d_r > lim_ext);
    match   = (lhs == rhs);
    gt      = (lhs > rhs);
  end

  assign status.over  = over;
  assign status.match = match;

  always_comb begin
    lo_n_nxt  = lo_n_r;
    lo_d_nxt  = lo_d_r;
    up_n_nxt  = up_n_r;
    up_d_nxt  = up_d_r;
    plo_nxt   = plo_r;
    pup_nxt   = pup_r;
    res_n_nxt = res_n_r;
    res_d_nxt = res_d_r;
    if (cmd.load) begin
      lo_n_nxt = '0;
      lo_d_nxt = BW'(1);
      up_n_nxt = BW'(1);
      up_d_nxt = BW'(1);
      plo_nxt  = PW'(tangent);
      pup_nxt  = PW'(tangent);
    end else if (cmd.step) begin
      if (gt) begin
        lo_n_nxt = m_n;
        lo_d_nxt = m_d;
        plo_nxt  = lhs;
      end else begin
        up_n_nxt = m_n;
        up_d_nxt = m_d;
        pup_nxt  = lhs;
      end
    end else if (cmd.finish) begin
      if (over) begin
        // keep the bound still within the limit
        if (lo_d_r > lim_ext) begin
          res_n_nxt = up_n_r;
          res_d_nxt = up_d_r;
        end else begin
          res_n_nxt = lo_n_r;
          res_d_nxt = lo_d_r;
        end
      end else if (m_d < lim_ext) begin
        res_n_nxt = m_n;
        res_d_nxt = m_d;
      end else if (up_d_r > lo_d_r) begin
        res_n_nxt = up_n_r;
        res_d_nxt = up_d_r;
      end else begin
        res_n_nxt = lo_n_r;
        res_d_nxt = lo_d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_n_r  <= lo_n_nxt;
    lo_d_r  <= lo_d_nxt;
    up_n_r  <= up_n_nxt;
    up_d_r  <= up_d_nxt;
    plo_r   <= plo_nxt;
    pup_r   <= pup_nxt;
    res_n_r <= res_n_nxt;
    res_d_r <= res_d_nxt;
  end

  assign res_num = res_n_r[DENOM_BITS-1:0];
  assign res_den = res_d_r[DENOM_BITS-1:0];

endmodule

// ----- rtl/bdfs_ctrl.sv -----
// Controller: walk sequencing and output handshake.
module bdfs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  bdfs_pkg::dp_status_t status,
  output bdfs_pkg::dp_cmd_t    cmd
);

  bdfs_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdfs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      bdfs_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = bdfs_pkg::S_STEP;
        end
      end
      bdfs_pkg::S_STEP: begin
        if (status.over || status.match) begin
          // hold until the result register is free
          if (!out_valid_r || out_tready) begin
            cmd.finish    = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = bdfs_pkg::S_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = bdfs_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- rtl/bounded_denominator_fraction_search_unit.sv -----
// Order: accept, the mediant steps, then the result load (held while the previous result waits).
// Steps per item: at most max_denominator, as every step raises the larger denominator.
// One item at a time: accept, walk, result load; the next is accepted only after the result load.
// The walk sets the rate: one mediant compare (one add, one compare) a cycle, one item at a time.
// A registered result lets the next item start while the previous one waits on out_tready.
// Reset (rst_n low at a clock edge) empties the block, sets max_denominator to min(16, 2**DENOM_BITS-1).
module bounded_denominator_fraction_search_unit #(
  parameter int unsigned FRACTION_BITS = bdfs_pkg::FRACTION_BITS_DEF,
  parameter int unsigned DENOM_BITS    = bdfs_pkg::DENOM_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // configuration: max_denominator
  input  logic                                      cfg_wr_en,
  input  logic [DENOM_BITS-1:0]                     cfg_wr_data,
  // input stream, tdata: tangent (Q1.FRACTION_BITS), zero padding
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((FRACTION_BITS+1+7)/8)*8-1:0]      in_tdata,
  // result stream, tdata: numerator, denominator, zero padding
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((2*DENOM_BITS+7)/8)*8-1:0]         out_tdata
);

  localparam int unsigned OUT_TW = ((2 * DENOM_BITS + 7) / 8) * 8;

  bdfs_pkg::dp_cmd_t     cmd;
  bdfs_pkg::dp_status_t  status;
  logic [DENOM_BITS-1:0] res_num, res_den;

  // Controller: takes one transfer in, steps the walk until a bound overruns
  // the limit or the mediant hits the value exactly, then loads the result.
  bdfs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: lower/upper bounds, running products of the value with each
  // denominator, the limit register and the result register.
  bdfs_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .DENOM_BITS    (DENOM_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tangent     (in_tdata[FRACTION_BITS:0]),
    .cmd         (cmd),
    .status      (status),
    .res_num     (res_num),
    .res_den     (res_den)
  );

  // Pack numerator low, denominator above it, zero pad to whole bytes.
  assign out_tdata = OUT_TW'({res_den, res_num});

endmodule

// ----- rtl/bdfs_checker.sv -----
// Port-level checker for the fraction search unit, with its bind.
`include "bounded_denominator_fraction_search_unit_macros.svh"

module bdfs_checker #(
  parameter int unsigned FRACTION_BITS = bdfs_pkg::FRACTION_BITS_DEF,
  parameter int unsigned DENOM_BITS    = bdfs_pkg::DENOM_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [((2*DENOM_BITS+7)/8)*8-1:0]     out_tdata
);

  logic [DENOM_BITS-1:0] num, den;
  logic                  in_xfer;

  assign num     = out_tdata[DENOM_BITS-1:0];
  assign den     = out_tdata[2*DENOM_BITS-1:DENOM_BITS];
  assign in_xfer = in_tvalid && in_tready;

  `BDFS_ASSERT_HOLD(a_out_valid_held, out_tvalid, out_tready, out_tvalid)
  `BDFS_ASSERT_HOLD(a_out_data_held, out_tvalid, out_tready, out_tdata)
  // a fraction of at most one with a nonzero denominator
  `BDFS_ASSERT_IMPL(a_fraction_proper, out_tvalid, (den != '0) && (num <= den))
  // no result can be ready the cycle after a transfer in
  `BDFS_ASSERT_NEXT(a_no_instant_result, in_xfer && (!out_tvalid || out_tready), !out_tvalid)

endmodule

bind bounded_denominator_fraction_search_unit bdfs_checker #(
  .FRACTION_BITS (FRACTION_BITS),
  .DENOM_BITS    (DENOM_BITS)
) u_bdfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the bounded-denominator fraction search unit.
`timescale 1ns / 1ps

// Holds the predicted fractions in order and compares the block's results against them.
class fraction_scoreboard;
  typedef struct {
    bit [16:0] tangent;
    bit [9:0]  numer;
    bit [9:0]  denom;
  } fraction_t;

  bit [9:0]  max_denom;
  fraction_t pending[$];
  int        errors;
  int        checked;

  function new();
    max_denom = 10'd16;
    errors    = 0;
    checked   = 0;
  endfunction

  function void set_limit(bit [9:0] limit);
    max_denom = limit;
  endfunction

  // Walk the mediant tree from 0/1 and 1/1 with exact cross-multiplied compares.
  function fraction_t best_fraction(bit [16:0] t);
    fraction_t  r;
    bit [10:0]  lo_n, lo_d, up_n, up_d, m_n, m_d;
    bit [31:0]  lhs, rhs;
    bit         hit;
    lo_n = 0; lo_d = 1; up_n = 1; up_d = 1;
    hit = 1'b0;
    r.tangent = t;
    r.numer   = 10'd0;
    r.denom   = 10'd1;
    while (lo_d <= 11'(max_denom) && up_d <= 11'(max_denom)) begin
      m_n = lo_n + up_n;
      m_d = lo_d + up_d;
      lhs = 32'(t) * 32'(m_d);
      rhs = 32'(m_n) << 16;
      if (lhs == rhs) begin
        if (m_d < 11'(max_denom)) begin
          r.numer = m_n[9:0]; r.denom = m_d[9:0];
        end else if (up_d > lo_d) begin
          r.numer = up_n[9:0]; r.denom = up_d[9:0];
        end else begin
          r.numer = lo_n[9:0]; r.denom = lo_d[9:0];
        end
        hit = 1'b1;
        break;
      end else if (lhs > rhs) begin
        lo_n = m_n; lo_d = m_d;
      end else begin
        up_n = m_n; up_d = m_d;
      end
    end
    if (!hit) begin
      if (lo_d > 11'(max_denom)) begin
        r.numer = up_n[9:0]; r.denom = up_d[9:0];
      end else begin
        r.numer = lo_n[9:0]; r.denom = lo_d[9:0];
      end
    end
    return r;
  endfunction

  function void note_tangent(bit [16:0] t);
    pending.push_back(best_fraction(t));
  endfunction

  function void check_result(bit [9:0] numer, bit [9:0] denom);
    fraction_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual %0d/%0d", $time, numer, denom);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (numer !== want.numer) begin
      errors++;
      $display("%0t: numerator for tangent 0x%05h: expected %0d, actual %0d",
               $time, want.tangent, want.numer, numer);
    end
    if (denom !== want.denom) begin
      errors++;
      $display("%0t: denominator for tangent 0x%05h: expected %0d, actual %0d",
               $time, want.tangent, want.denom, denom);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned FRAC_W   = bdfs_pkg::FRACTION_BITS_DEF;
  localparam int unsigned DEN_W    = bdfs_pkg::DENOM_BITS_DEF;
  localparam int unsigned IN_W     = ((FRAC_W + 1 + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((2 * DEN_W + 7) / 8) * 8;
  localparam int          N_PHASES = 19;
  // A walk has at most as many steps as the limit; the settle time at the end outlasts the longest one.
  localparam int          SETTLE   = 2 * 1023 + 16;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_wr_en  = 1'b0;
  logic [DEN_W-1:0]  cfg_wr_data = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;   // tangent [16:0], zero padding above
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [OUT_W-1:0]  out_tdata;         // numerator [9:0], denominator [19:10], zero padding

  fraction_scoreboard sb = new();

  // Idle percentages for the current phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_items        = 0;

  bounded_denominator_fraction_search_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous ceiling: far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("bounded_denominator_fraction_search_unit: mismatch");
    $finish;
  end

  // Receiver: decide ready on the falling edge, stalling at the phase's rate.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check every result transfer at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[DEN_W-1:0], out_tdata[2*DEN_W-1:DEN_W]);
    end
  end

  // Offer one tangent, idling beforehand at the phase's rate; hold until the transfer.
  task automatic send_tangent(input bit [16:0] t);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(t);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tangent(t);
    n_items++;
  endtask

  // Drop valid and wait until every predicted fraction has come back.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write max_denominator; only called with the block idle.
  task automatic write_limit(input bit [9:0] limit);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_limit(limit);
  endtask

  // Random tangent, weighted towards the interesting regions of the walk.
  function automatic bit [16:0] random_tangent();
    int s, k, p, q;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 17'($urandom_range(0, 17'h1FFFF));
      4, 5: begin
        // dyadic values: the only ones a mediant can hit exactly
        s = $urandom_range(1, 10);
        k = $urandom_range(1, (1 << s) - 1);
        return 17'(k << (16 - s));
      end
      6: return 17'($urandom_range(0, 255));
      7: return 17'(17'h10000 - $urandom_range(1, 256));
      8: return 17'($urandom_range(17'h10000, 17'h1FFFF));
      default: begin
        // close to a fraction with a small denominator
        q = $urandom_range(1, 1023);
        p = $urandom_range(0, q);
        k = ((p << 16) / q) + $urandom_range(0, 2) - 1;
        if (k < 0) k = 0;
        return 17'(k);
      end
    endcase
  endfunction

  initial begin
    bit [16:0] dir_reset[14] = '{17'h00000, 17'h00001, 17'h1FFFF, 17'h10000, 17'h0FFFF,
                                 17'h08000, 17'h0C000, 17'h05555, 17'h0AAAA, 17'h15555,
                                 17'h0A000, 17'h01000, 17'h0F000, 17'h00800};
    bit [16:0] dir_one[4]   = '{17'h00000, 17'h08000, 17'h1FFFF, 17'h0FFFF};
    bit [16:0] dir_wide[4]  = '{17'h00001, 17'h0FFFF, 17'h1FFFF, 17'h00040};
    bit [9:0]  limit;
    int        count;
    int        r;

    // Hold reset, then release at a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // Rotate through: no idling, sender idle, receiver stalling, both lightly.
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase

      // Pick the limit: reset value first, then the extremes, then mostly small ones.
      case (ph)
        0: limit = 10'd16;
        1: limit = 10'd1;
        2: limit = 10'd1023;
        3: limit = 10'd2;
        4: limit = 10'd3;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0)      limit = 10'($urandom_range(256, 1023));
          else if (r == 9) limit = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd1;
          else             limit = 10'($urandom_range(1, 64));
        end
      endcase
      if (ph != 0) write_limit(limit);

      // Directed corners for the first few settings.
      case (ph)
        0: foreach (dir_reset[i]) send_tangent(dir_reset[i]);
        1: foreach (dir_one[i]) send_tangent(dir_one[i]);
        2: foreach (dir_wide[i]) send_tangent(dir_wide[i]);
        3: send_tangent(17'h08000);   // exact hit with the mediant at the limit
        default: ;
      endcase

      // Large limits mean long walks: keep those phases short.
      count = (limit > 10'd128) ? 30 : 100;
      for (int i = 0; i < count; i++) send_tangent(random_tangent());

      drain();
    end

    // Nothing is in flight; let any stray result show up before the verdict.
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d tangents over %0d limit settings (1 to 1023), %0d fractions checked.",
             n_items, N_PHASES, sb.checked);
    $display("Idling covered none, sender only, receiver only and both; %0d errors.",
             sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bounded_denominator_fraction_search_unit: match");
    end else begin
      $display("bounded_denominator_fraction_search_unit: mismatch");
    end
    $finish;
  end

endmodule
